// File: design/quadratic_root_solver_unit_assert.svh
// Assertion macros for the quadratic root solver.
// Included by RTL files that check their own behavior; needs no package.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define QRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("qrs assertion failed");
// condition must never be true outside reset
`define QRS_ASSERT_NEVER(lbl, clk, rst, cond) \
   `QRS_ASSERT(lbl, clk, rst, !(cond))
`else
`define QRS_ASSERT(lbl, clk, rst, prop)
`define QRS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: design/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies.
`default_nettype none
package qrs_pkg;
   localparam int COEF_W = 16;
   localparam int VAL_W  = 32;

   typedef enum logic [1:0] {
      KIND_REPEATED = 2'd0,
      KIND_COMPLEX  = 2'd1,
      KIND_TWO_REAL = 2'd2,
      KIND_REJECTED = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } req_type;

   typedef struct packed {
      kind_type                root_kind;
      logic signed [VAL_W-1:0] first_value;
      logic signed [VAL_W-1:0] second_value;
      logic                    saturated;
   } rsp_type;
endpackage
`default_nettype wire

// File: design/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: front end, root, divider, output.
// Depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div and the assertion header.
//
//   channel   ports                         payload
//   request   req_valid req_stall req_data  qrs_pkg::req_type (a, b, c in Q8.8)
//   response  rsp_valid rsp_stall rsp_data  qrs_pkg::rsp_type (kind, Q16.16 roots)
//
// One transaction enters per cycle and one leaves per cycle, in order, unless
// the response is stalled. The square root makes one root bit per stage and
// the divider one quotient bit per stage.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// A stalled response freezes the whole pipeline in place; req_stall rises
// only while the output register holds a transaction that is not taken.
`default_nettype none
`include "quadratic_root_solver_unit_assert.svh"
module quadratic_root_solver_unit #(
   parameter int OUT_FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire qrs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output qrs_pkg::rsp_type      rsp_data
);
   import qrs_pkg::*;

   localparam int FRAC   = OUT_FRAC_BITS;
   localparam int RW     = 2*COEF_W+1 + 2*FRAC;
   localparam int RW2    = RW + (RW % 2);
   localparam int SW     = RW2 / 2;
   localparam int BW     = COEF_W+FRAC+1;
   localparam int DNW    = COEF_W+1;
   localparam int SIDE_W = 2 + DNW + BW;

   // pipeline advances whenever the output slot is free or being drained
   logic en;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // discriminant
   logic                 fe_valid;
   logic [RW2-1:0]       fe_rad;
   kind_type             fe_kind;
   logic [DNW-1:0]       fe_den;
   logic signed [BW-1:0] fe_bn;

   qrs_front #(.FRAC(FRAC)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fe_valid),
      .out_rad   (fe_rad),
      .out_kind  (fe_kind),
      .out_den   (fe_den),
      .out_bn    (fe_bn)
   );

   // square root of |D| scaled by 2^(2F); kind, divisor and -b*sign(a) ride alongside
   logic              sq_valid;
   logic [SW-1:0]     sq_root;
   logic [SIDE_W-1:0] sq_side;

   qrs_sqrt #(.FRAC(FRAC), .SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fe_valid),
      .in_rad    (fe_rad),
      .in_side   ({fe_kind, fe_den, fe_bn}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // divide by 2|a|, floor, clamp
   logic                    dv_valid;
   kind_type                dv_kind;
   logic signed [VAL_W-1:0] dv_first, dv_second;
   logic                    dv_sat;

   qrs_div #(.FRAC(FRAC)) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (sq_valid),
      .in_kind    (kind_type'(sq_side[SIDE_W-1 -: 2])),
      .in_den     (sq_side[BW +: DNW]),
      .in_bn      (signed'(sq_side[BW-1:0])),
      .in_root    (sq_root),
      .out_valid  (dv_valid),
      .out_kind   (dv_kind),
      .out_first  (dv_first),
      .out_second (dv_second),
      .out_sat    (dv_sat)
   );

   // zero a: the divider ran on a zero divisor, so its values are dropped
   always_comb begin
      rsp_in.root_kind = dv_kind;
      if (dv_kind == KIND_REJECTED) begin
         rsp_in.first_value  = '0;
         rsp_in.second_value = '0;
         rsp_in.saturated    = 1'b0;
      end else begin
         rsp_in.first_value  = dv_first;
         rsp_in.second_value = dv_second;
         rsp_in.saturated    = dv_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // real roots come out larger first
   `QRS_ASSERT(a_two_real_order, clock, reset, rsp_valid && rsp_data.root_kind == KIND_TWO_REAL |-> rsp_data.first_value >= rsp_data.second_value)
   // imaginary magnitude never negative
   `QRS_ASSERT_NEVER(a_imag_sign, clock, reset, rsp_valid && rsp_data.root_kind == KIND_COMPLEX && rsp_data.second_value[VAL_W-1])
   // repeated root carries the same value twice
   `QRS_ASSERT(a_repeated_same, clock, reset, rsp_valid && rsp_data.root_kind == KIND_REPEATED |-> rsp_data.first_value == rsp_data.second_value)
   // rejected transactions carry clean zeros
   `QRS_ASSERT(a_rejected_zero, clock, reset, rsp_valid && rsp_data.root_kind == KIND_REJECTED |-> rsp_data.first_value == '0 && rsp_data.second_value == '0 && !rsp_data.saturated)
endmodule
`default_nettype wire

// File: design/qrs_front.sv
// Front end: coefficient magnitudes, products and discriminant (two stages).
// Depends on qrs_pkg.
`default_nettype none
module qrs_front #(
   parameter int FRAC = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire qrs_pkg::req_type    in_data,
   output logic                     out_valid,
   output logic [2*qrs_pkg::COEF_W+1+2*FRAC+((2*qrs_pkg::COEF_W+1+2*FRAC)%2)-1:0] out_rad,
   output qrs_pkg::kind_type        out_kind,
   output logic [qrs_pkg::COEF_W:0] out_den,
   output logic signed [qrs_pkg::COEF_W+FRAC:0] out_bn
);
   import qrs_pkg::*;

   localparam int DW  = 2*COEF_W+1;
   localparam int RW  = DW + 2*FRAC;
   localparam int RW2 = RW + (RW % 2);
   localparam int BW  = COEF_W+FRAC+1;

   // stage 1
   logic                     s1_valid_ff;
   logic [2*COEF_W-1:0]      s1_b2_ff, s1_ac_ff;
   logic [COEF_W-1:0]        s1_ua_ff;
   logic signed [COEF_W-1:0] s1_b_ff;
   logic                     s1_apos_ff, s1_azero_ff, s1_add_ff;

   logic [COEF_W-1:0]   ua, ub, uc;
   logic [2*COEF_W-1:0] b2_in, ac_in;

   assign ua = in_data.coef_a[COEF_W-1] ? COEF_W'(-in_data.coef_a) : in_data.coef_a;
   assign ub = in_data.coef_b[COEF_W-1] ? COEF_W'(-in_data.coef_b) : in_data.coef_b;
   assign uc = in_data.coef_c[COEF_W-1] ? COEF_W'(-in_data.coef_c) : in_data.coef_c;
   assign b2_in = (2*COEF_W)'(ub) * (2*COEF_W)'(ub);
   assign ac_in = (2*COEF_W)'(ua) * (2*COEF_W)'(uc);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_b2_ff    <= b2_in;
         s1_ac_ff    <= ac_in;
         s1_ua_ff    <= ua;
         s1_b_ff     <= in_data.coef_b;
         s1_apos_ff  <= !in_data.coef_a[COEF_W-1];
         s1_azero_ff <= (in_data.coef_a == '0);
         // opposite signs or zero c: discriminant is b*b + 4|ac|
         s1_add_ff   <= (in_data.coef_a[COEF_W-1] != in_data.coef_c[COEF_W-1])
                        || (in_data.coef_c == '0);
      end
   end

   // stage 2
   logic [DW-1:0]        b2x, ac4, dmag_in;
   logic                 dneg_in;
   kind_type             kind_in;
   logic signed [BW-1:0] bext, bsh, bn_in;

   assign b2x = DW'(s1_b2_ff);
   assign ac4 = DW'({s1_ac_ff, 2'b00});

   always_comb begin
      dneg_in = 1'b0;
      if (s1_add_ff) begin
         dmag_in = b2x + ac4;
      end else if (b2x >= ac4) begin
         dmag_in = b2x - ac4;
      end else begin
         dmag_in = ac4 - b2x;
         dneg_in = 1'b1;
      end
      if (s1_azero_ff) begin
         kind_in = KIND_REJECTED;
      end else if (dmag_in == '0) begin
         kind_in = KIND_REPEATED;
      end else if (dneg_in) begin
         kind_in = KIND_COMPLEX;
      end else begin
         kind_in = KIND_TWO_REAL;
      end
   end

   assign bext  = signed'({{(FRAC+1){s1_b_ff[COEF_W-1]}}, s1_b_ff});
   assign bsh   = bext <<< FRAC;
   assign bn_in = s1_apos_ff ? -bsh : bsh;

   logic                 s2_valid_ff;
   logic [DW-1:0]        s2_dmag_ff;
   kind_type             s2_kind_ff;
   logic [COEF_W:0]      s2_den_ff;
   logic signed [BW-1:0] s2_bn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_dmag_ff <= dmag_in;
         s2_kind_ff <= kind_in;
         s2_den_ff  <= {s1_ua_ff, 1'b0};
         s2_bn_ff   <= bn_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_rad   = RW2'({s2_dmag_ff, {(2*FRAC){1'b0}}});
   assign out_kind  = s2_kind_ff;
   assign out_den   = s2_den_ff;
   assign out_bn    = s2_bn_ff;
endmodule
`default_nettype wire

// File: design/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband.
// Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt #(
   parameter int FRAC   = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2*qrs_pkg::COEF_W+1+2*FRAC+((2*qrs_pkg::COEF_W+1+2*FRAC)%2)-1:0] in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [(2*qrs_pkg::COEF_W+1+2*FRAC+((2*qrs_pkg::COEF_W+1+2*FRAC)%2))/2-1:0]
                                  out_root,
   output logic [SIDE_W-1:0]      out_side
);
   import qrs_pkg::*;

   localparam int RW  = 2*COEF_W+1 + 2*FRAC;
   localparam int RW2 = RW + (RW % 2);
   localparam int SW  = RW2 / 2;

   logic              v_ff    [SW];
   logic [SW+1:0]     rem_ff  [SW];
   logic [SW-1:0]     root_ff [SW];
   logic [RW2-1:0]    rad_ff  [SW];
   logic [SIDE_W-1:0] side_ff [SW];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic              pv;
      logic [SW+1:0]     prem;
      logic [SW-1:0]     proot;
      logic [RW2-1:0]    prad;
      logic [SIDE_W-1:0] pside;
      logic [SW+3:0]     cur, trial, diff;
      logic              fit;
      logic [SW+1:0]     rem_in;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign prad  = in_rad;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign prad  = rad_ff[k-1];
         assign pside = side_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      assign cur    = {prem, prad[RW2-1 -: 2]};
      assign trial  = (SW+4)'({proot, 2'b01});
      assign fit    = (cur >= trial);
      assign diff   = cur - trial;
      assign rem_in = fit ? diff[SW+1:0] : cur[SW+1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {proot[SW-2:0], fit};
            rad_ff[k]  <= prad << 2;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = v_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_side  = side_ff[SW-1];
endmodule
`default_nettype wire

// File: design/qrs_div.sv
// Two-lane pipelined floor divider by 2|a|, one quotient bit per stage,
// with Q16.16 clamping. Depends on qrs_pkg.
`default_nettype none
module qrs_div #(
   parameter int FRAC = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire qrs_pkg::kind_type   in_kind,
   input  wire logic [qrs_pkg::COEF_W:0] in_den,
   input  wire logic signed [qrs_pkg::COEF_W+FRAC:0] in_bn,
   input  wire logic [(2*qrs_pkg::COEF_W+1+2*FRAC+((2*qrs_pkg::COEF_W+1+2*FRAC)%2))/2-1:0]
                                    in_root,
   output logic                     out_valid,
   output qrs_pkg::kind_type        out_kind,
   output logic signed [qrs_pkg::VAL_W-1:0] out_first,
   output logic signed [qrs_pkg::VAL_W-1:0] out_second,
   output logic                     out_sat
);
   import qrs_pkg::*;

   localparam int RW  = 2*COEF_W+1 + 2*FRAC;
   localparam int RW2 = RW + (RW % 2);
   localparam int SW  = RW2 / 2;
   localparam int NW  = ((COEF_W+FRAC > SW) ? COEF_W+FRAC : SW) + 1;
   localparam int DNW = COEF_W+1;
   localparam int XW  = (NW+2 > VAL_W+1) ? NW+2 : VAL_W+1;

   // numerator select and magnitude
   logic signed [NW:0] sx, bx, num0, num1;
   logic [NW-1:0]      mag0, mag1;

   assign sx = signed'((NW+1)'(in_root));
   assign bx = (NW+1)'(in_bn);

   always_comb begin
      case (in_kind)
         KIND_TWO_REAL: begin
            num0 = bx + sx;
            num1 = bx - sx;
         end
         KIND_COMPLEX: begin
            num0 = bx;
            num1 = sx;
         end
         default: begin
            num0 = bx;
            num1 = bx;
         end
      endcase
   end

   assign mag0 = num0[NW] ? NW'(-num0) : NW'(num0);
   assign mag1 = num1[NW] ? NW'(-num1) : NW'(num1);

   logic           p_valid_ff;
   kind_type       p_kind_ff;
   logic [DNW-1:0] p_den_ff;
   logic [1:0]     p_neg_ff;
   logic [NW-1:0]  p_mag_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
      end
      if (en) begin
         p_kind_ff   <= in_kind;
         p_den_ff    <= in_den;
         p_neg_ff    <= {num1[NW], num0[NW]};
         p_mag_ff[0] <= mag0;
         p_mag_ff[1] <= mag1;
      end
   end

   // restoring division: quotient bits shift in as numerator bits shift out
   logic           dv_ff [NW];
   kind_type       dk_ff [NW];
   logic [DNW-1:0] dd_ff [NW];
   logic [1:0]     dn_ff [NW];
   logic [DNW-1:0] dr_ff [NW][2];
   logic [NW-1:0]  dq_ff [NW][2];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic           pv;
      kind_type       pk;
      logic [DNW-1:0] pd;
      logic [1:0]     pn;
      logic [DNW-1:0] pr [2];
      logic [NW-1:0]  pq [2];

      if (k == 0) begin : g_first
         assign pv    = p_valid_ff;
         assign pk    = p_kind_ff;
         assign pd    = p_den_ff;
         assign pn    = p_neg_ff;
         assign pr[0] = '0;
         assign pr[1] = '0;
         assign pq[0] = p_mag_ff[0];
         assign pq[1] = p_mag_ff[1];
      end else begin : g_next
         assign pv    = dv_ff[k-1];
         assign pk    = dk_ff[k-1];
         assign pd    = dd_ff[k-1];
         assign pn    = dn_ff[k-1];
         assign pr[0] = dr_ff[k-1][0];
         assign pr[1] = dr_ff[k-1][1];
         assign pq[0] = dq_ff[k-1][0];
         assign pq[1] = dq_ff[k-1][1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DNW:0]   t, tdiff;
         logic           fit;
         logic [DNW-1:0] rem_in;

         assign t      = {pr[l], pq[l][NW-1]};
         assign fit    = (t >= {1'b0, pd});
         assign tdiff  = t - {1'b0, pd};
         assign rem_in = fit ? tdiff[DNW-1:0] : t[DNW-1:0];

         always_ff @(posedge clock) begin
            if (en) begin
               dr_ff[k][l] <= rem_in;
               dq_ff[k][l] <= {pq[l][NW-2:0], fit};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= pv;
         end
         if (en) begin
            dk_ff[k] <= pk;
            dd_ff[k] <= pd;
            dn_ff[k] <= pn;
         end
      end
   end

   // floor for negative numerators, then clamp
   localparam logic signed [XW-1:0] VMAX = XW'({(VAL_W-1){1'b1}});
   localparam logic signed [XW-1:0] VMIN = -VMAX - XW'(1);

   logic signed [VAL_W-1:0] res [2];
   logic [1:0]              sat;

   for (genvar l = 0; l < 2; l++) begin : g_fin
      logic signed [XW-1:0] qv, val;
      assign qv  = signed'(XW'(dq_ff[NW-1][l]));
      assign val = dn_ff[NW-1][l]
                   ? -(qv + XW'(dr_ff[NW-1][l] != '0)) : qv;
      assign sat[l] = (val > VMAX) || (val < VMIN);
      assign res[l] = (val > VMAX) ? VMAX[VAL_W-1:0]
                    : (val < VMIN) ? VMIN[VAL_W-1:0] : val[VAL_W-1:0];
   end

   assign out_valid  = dv_ff[NW-1];
   assign out_kind   = dk_ff[NW-1];
   assign out_first  = res[0];
   assign out_second = res[1];
   assign out_sat    = |sat;
endmodule
`default_nettype wire
